>>> rtl/apcp_pkg.sv
// ----------------------------------------------------------------------------
// ASCII port command parser package
// Beat types, reply descriptors and character codes shared by the parser.
// ----------------------------------------------------------------------------
package apcp_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CHAR_S = 8'h53;
    localparam logic [7:0] CHAR_G = 8'h47;
    localparam logic [7:0] CHAR_X = 8'h58;
    localparam logic [7:0] CHAR_E = 8'h45;
    localparam logic [7:0] CHAR_R = 8'h52;
    localparam logic [7:0] CHAR_T = 8'h54;

    localparam logic [7:0] LATCH_A_RESET = 8'hFF;
    localparam logic [7:0] LATCH_B_RESET = 8'hF0;
    localparam logic [7:0] LATCH_C_RESET = 8'h00;

    typedef enum logic [1:0] {
        REPLY_ERR,
        REPLY_SET,
        REPLY_GET,
        REPLY_RST
    } reply_kind_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic [7:0] pins_a;
        logic [7:0] pins_b;
        logic [7:0] pins_c;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] tx_char;
        logic       last_char;
        logic [7:0] latch_a;
        logic [7:0] latch_b;
        logic [7:0] latch_c;
    } out_beat_t;

    typedef struct packed {
        reply_kind_t kind;
        logic        bad_port;
        logic [7:0]  value;
        logic [7:0]  latch_a;
        logic [7:0]  latch_b;
        logic [7:0]  latch_c;
    } reply_desc_t;

endpackage

>>> rtl/apcp_front.sv
// ----------------------------------------------------------------------------
// ASCII port command parser front end
// Collects command bytes, executes complete commands on the port latches and
// issues one reply descriptor per executed command.
// ----------------------------------------------------------------------------
module apcp_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  apcp_pkg::in_beat_t   beat,
    output logic                 push,
    output apcp_pkg::reply_desc_t desc
);

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h61 && c <= 8'h66)
        begin
            v = 4'(c - 8'h57);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            v = 4'(c - 8'h37);
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            v = 4'(c - 8'h30);
        end
        return v;
    endfunction

    logic [7:0] held_chars_reg [3];
    logic [1:0] held_count_reg;
    logic [1:0] held_count_next;
    logic [7:0] latch_a_reg, latch_b_reg, latch_c_reg;
    logic [7:0] latch_a_next, latch_b_next, latch_c_next;

    logic [7:0] cmd0;
    logic [7:0] cmd1;
    logic       is_set;
    logic       is_get;
    logic       incomplete;
    logic [3:0] port;
    logic [7:0] set_value;
    logic [7:0] get_value;
    logic       bad_port;

    always_comb
    begin
        cmd0       = (held_count_reg == 2'd0) ? beat.rx_byte : held_chars_reg[0];
        cmd1       = (held_count_reg == 2'd1) ? beat.rx_byte : held_chars_reg[1];
        is_set     = (cmd0 == apcp_pkg::CHAR_S);
        is_get     = (cmd0 == apcp_pkg::CHAR_G);
        incomplete = (is_set && held_count_reg != 2'd3) || (is_get && held_count_reg == 2'd0);
        port       = hex_value(cmd1);
        set_value  = {hex_value(held_chars_reg[2]), hex_value(beat.rx_byte)};
        bad_port   = (port > 4'd2);

        case (port)
            4'd0:    get_value = beat.pins_a;
            4'd1:    get_value = beat.pins_b;
            4'd2:    get_value = beat.pins_c;
            default: get_value = 8'h00;
        endcase

        latch_a_next = latch_a_reg;
        latch_b_next = latch_b_reg;
        latch_c_next = latch_c_reg;
        if (accept && !incomplete && (is_set || is_get))
        begin
            case (port)
                4'd0:    latch_a_next = is_set ? set_value : 8'hFF;
                4'd1:    latch_b_next = is_set ? set_value : 8'hFF;
                4'd2:    latch_c_next = is_set ? set_value : 8'hFF;
                default: ;
            endcase
        end

        held_count_next = held_count_reg;
        if (accept)
        begin
            held_count_next = incomplete ? held_count_reg + 2'd1 : 2'd0;
        end

        push          = accept && !incomplete;
        desc.bad_port = (is_set || is_get) && bad_port;
        desc.value    = get_value;
        desc.latch_a  = latch_a_next;
        desc.latch_b  = latch_b_next;
        desc.latch_c  = latch_c_next;
        if (is_set)
        begin
            desc.kind = apcp_pkg::REPLY_SET;
        end
        else if (is_get)
        begin
            desc.kind = apcp_pkg::REPLY_GET;
        end
        else if (cmd0 == apcp_pkg::CHAR_X)
        begin
            desc.kind = apcp_pkg::REPLY_RST;
        end
        else
        begin
            desc.kind = apcp_pkg::REPLY_ERR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg <= 2'd0;
            latch_a_reg    <= apcp_pkg::LATCH_A_RESET;
            latch_b_reg    <= apcp_pkg::LATCH_B_RESET;
            latch_c_reg    <= apcp_pkg::LATCH_C_RESET;
        end
        else
        begin
            held_count_reg <= held_count_next;
            latch_a_reg    <= latch_a_next;
            latch_b_reg    <= latch_b_next;
            latch_c_reg    <= latch_c_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && incomplete)
        begin
            held_chars_reg[held_count_reg] <= beat.rx_byte;
        end
    end

    // A partial command always starts with a set or get opcode.
    assert property (@(posedge clk) disable iff (!rst_n)
        held_count_reg != 2'd0 |->
            (held_chars_reg[0] == apcp_pkg::CHAR_S || held_chars_reg[0] == apcp_pkg::CHAR_G))
        else $error("partial command without set or get opcode");

endmodule

>>> rtl/apcp_queue.sv
// ----------------------------------------------------------------------------
// ASCII port command parser reply queue
// Small first-in first-out buffer of reply descriptors between the two halves.
// ----------------------------------------------------------------------------
module apcp_queue
#(
    parameter int DEPTH = apcp_pkg::QUEUE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  apcp_pkg::reply_desc_t push_data,
    output logic                  full,
    input  logic                  pop,
    output logic                  pop_valid,
    output apcp_pkg::reply_desc_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    apcp_pkg::reply_desc_t entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("reply queue overflow");

    assert property (@(posedge clk) disable iff (!rst_n) !(pop && !pop_valid))
        else $error("reply queue underflow");

endmodule

>>> rtl/apcp_back.sv
// ----------------------------------------------------------------------------
// ASCII port command parser back end
// Expands reply descriptors into reply characters, one beat per cycle unless stalled.
// ----------------------------------------------------------------------------
module apcp_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  apcp_pkg::reply_desc_t q_data,
    output logic                  q_pop,
    output logic                  reply_valid,
    input  logic                  reply_ready,
    output apcp_pkg::out_beat_t   reply
);

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        return (nib <= 4'd9) ? {4'h0, nib} + 8'h30 : {4'h0, nib} + 8'h37;
    endfunction

    apcp_pkg::reply_desc_t cur_reg;
    logic                  cur_valid_reg;
    logic [2:0]            idx_reg;
    apcp_pkg::out_beat_t   out_reg;
    logic                  out_valid_reg;

    logic [2:0] len;
    logic [2:0] pos;
    logic [7:0] ch;
    logic       load;
    logic       last;

    always_comb
    begin
        pos = idx_reg - {2'b00, cur_reg.bad_port};
        ch  = apcp_pkg::CHAR_E;
        case (cur_reg.kind)
            apcp_pkg::REPLY_SET:
            begin
                len = 3'd1 + {2'b00, cur_reg.bad_port};
                if (!(cur_reg.bad_port && idx_reg == 3'd0))
                begin
                    ch = apcp_pkg::CHAR_S;
                end
            end
            apcp_pkg::REPLY_GET:
            begin
                len = 3'd3 + {2'b00, cur_reg.bad_port};
                if (!(cur_reg.bad_port && idx_reg == 3'd0))
                begin
                    case (pos)
                        3'd0:    ch = apcp_pkg::CHAR_G;
                        3'd1:    ch = hex_char(cur_reg.value[7:4]);
                        default: ch = hex_char(cur_reg.value[3:0]);
                    endcase
                end
            end
            apcp_pkg::REPLY_RST:
            begin
                len = 3'd5;
                case (idx_reg)
                    3'd0:    ch = apcp_pkg::CHAR_R;
                    3'd1:    ch = apcp_pkg::CHAR_E;
                    3'd2:    ch = apcp_pkg::CHAR_S;
                    3'd3:    ch = apcp_pkg::CHAR_E;
                    default: ch = apcp_pkg::CHAR_T;
                endcase
            end
            default:
            begin
                len = 3'd1;
            end
        endcase

        load  = cur_valid_reg && (!out_valid_reg || reply_ready);
        last  = (idx_reg == len - 3'd1);
        q_pop = q_valid && (!cur_valid_reg || (load && last));
    end

    assign reply_valid = out_valid_reg;
    assign reply       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= 3'd0;
            end
            else if (load)
            begin
                cur_valid_reg <= !last;
                idx_reg       <= last ? 3'd0 : idx_reg + 3'd1;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (reply_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_data;
        end
        if (load)
        begin
            out_reg.tx_char   <= ch;
            out_reg.last_char <= last;
            out_reg.latch_a   <= cur_reg.latch_a;
            out_reg.latch_b   <= cur_reg.latch_b;
            out_reg.latch_c   <= cur_reg.latch_c;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cur_valid_reg |-> idx_reg < len)
        else $error("reply index beyond reply length");

    // A waiting beat that is not the final one implies its reply is still in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.last_char) |-> cur_valid_reg)
        else $error("non-final beat without a reply in progress");

endmodule

>>> rtl/ascii_port_command_parser.sv
// ----------------------------------------------------------------------------
// ASCII port command parser
// Parses serial command bytes and drives three 8-bit port latches.
// ----------------------------------------------------------------------------
// Each cmd beat carries one received byte and the current pin levels of the
// three ports. Complete commands are executed at once in the front end, which
// updates the port latches and queues a reply descriptor. The back end turns
// each descriptor into one to five reply beats on the reply channel, one per
// cycle unless reply_ready stalls it; last_char marks the final character of a
// reply and every beat carries the latch values after its command.
// A cmd beat is taken in every cycle while the reply queue has room. The
// descriptor of a completed command passes through the queue, the current
// reply register and the output register before its first character shows.
// Sustained throughput is set by the serializing back end: one byte per cycle
// for short-reply commands, lower when each byte has a five-character reply.
// Reset clears the pending command and loads the latches with 0xFF, 0xF0 and
// 0x00. When the receiver stalls, the output register holds its beat, the
// queue fills, and cmd_ready falls until the back end drains again.
// ----------------------------------------------------------------------------
module ascii_port_command_parser
#(
    parameter int QUEUE_DEPTH = apcp_pkg::QUEUE_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  apcp_pkg::in_beat_t  cmd,
    output logic                reply_valid,
    input  logic                reply_ready,
    output apcp_pkg::out_beat_t reply
);

    logic                  accept;
    logic                  push;
    apcp_pkg::reply_desc_t push_desc;
    logic                  q_full;
    logic                  q_pop;
    logic                  q_valid;
    apcp_pkg::reply_desc_t q_data;

    assign cmd_ready = !q_full;
    assign accept    = cmd_valid && cmd_ready;

    apcp_front u_front
    (
        .clk   (clk),
        .rst_n (rst_n),
        .accept(accept),
        .beat  (cmd),
        .push  (push),
        .desc  (push_desc)
    );

    apcp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(push_desc),
        .full     (q_full),
        .pop      (q_pop),
        .pop_valid(q_valid),
        .pop_data (q_data)
    );

    apcp_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_data     (q_data),
        .q_pop      (q_pop),
        .reply_valid(reply_valid),
        .reply_ready(reply_ready),
        .reply      (reply)
    );

endmodule

>>> verif/apcp_reply_checker.sv
// ----------------------------------------------------------------------------
// ASCII port command parser reply checker
// Watches the cmd and reply channels and keeps its own copy of the pending
// command and the port latches. It works out the reply beats that each
// accepted cmd beat must produce and compares every accepted reply beat,
// field by field, with the oldest beat still owed.
// ----------------------------------------------------------------------------
module apcp_reply_checker
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  logic                cmd_ready,
    input  apcp_pkg::in_beat_t  cmd,
    input  logic                reply_valid,
    input  logic                reply_ready,
    input  apcp_pkg::out_beat_t reply,
    output int                  mismatch_total,
    output int                  replies_owed
);

    logic [7:0]          held_bytes [3];
    logic [1:0]          held_len;
    logic [7:0]          port_latch [3];
    apcp_pkg::out_beat_t owed_replies [$];

    // Characters outside 0-9, A-F and a-f count as zero.
    function automatic logic [3:0] char_to_nibble(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c >= "a" && c <= "f")
        begin
            v = c - "a" + 8'd10;
        end
        else if (c >= "A" && c <= "F")
        begin
            v = c - "A" + 8'd10;
        end
        else if (c >= "0" && c <= "9")
        begin
            v = c - "0";
        end
        return v[3:0];
    endfunction

    function automatic logic [7:0] nibble_to_char(input logic [3:0] n);
        logic [7:0] wide;
        wide = {4'd0, n};
        return (n <= 4'd9) ? ("0" + wide) : ("A" + wide - 8'd10);
    endfunction

    function automatic void take_cmd_beat(input apcp_pkg::in_beat_t beat);
        logic [7:0]          lead;
        logic [7:0]          port_char;
        logic [3:0]          port;
        logic [7:0]          value;
        logic [7:0]          pins [3];
        logic [7:0]          reset_word [5];
        logic [7:0]          chars [$];
        int                  count;
        apcp_pkg::out_beat_t b;
        pins = '{beat.pins_a, beat.pins_b, beat.pins_c};
        reset_word = '{apcp_pkg::CHAR_R, apcp_pkg::CHAR_E, apcp_pkg::CHAR_S,
                       apcp_pkg::CHAR_E, apcp_pkg::CHAR_T};
        lead = (held_len == 2'd0) ? beat.rx_byte : held_bytes[0];
        count = int'(held_len) + 1;
        if (lead == apcp_pkg::CHAR_S || lead == apcp_pkg::CHAR_G)
        begin
            if (count < ((lead == apcp_pkg::CHAR_S) ? 4 : 2))
            begin
                held_bytes[held_len] = beat.rx_byte;
                held_len = held_len + 2'd1;
                return;
            end
            port_char = (lead == apcp_pkg::CHAR_G) ? beat.rx_byte : held_bytes[1];
            port = char_to_nibble(port_char);
            if (lead == apcp_pkg::CHAR_S)
            begin
                value = {char_to_nibble(held_bytes[2]), char_to_nibble(beat.rx_byte)};
                if (port < 4'd3)
                begin
                    port_latch[port[1:0]] = value;
                end
                else
                begin
                    chars.push_back(apcp_pkg::CHAR_E);
                end
                chars.push_back(apcp_pkg::CHAR_S);
            end
            else
            begin
                value = 8'h00;
                if (port < 4'd3)
                begin
                    port_latch[port[1:0]] = 8'hFF;
                    value = pins[port[1:0]];
                end
                else
                begin
                    chars.push_back(apcp_pkg::CHAR_E);
                end
                chars.push_back(apcp_pkg::CHAR_G);
                chars.push_back(nibble_to_char(value[7:4]));
                chars.push_back(nibble_to_char(value[3:0]));
            end
        end
        else if (lead == apcp_pkg::CHAR_X)
        begin
            foreach (reset_word[i])
            begin
                chars.push_back(reset_word[i]);
            end
        end
        else
        begin
            chars.push_back(apcp_pkg::CHAR_E);
        end
        held_len = 2'd0;
        foreach (chars[i])
        begin
            b.tx_char = chars[i];
            b.last_char = (i == chars.size() - 1);
            b.latch_a = port_latch[0];
            b.latch_b = port_latch[1];
            b.latch_c = port_latch[2];
            owed_replies.push_back(b);
        end
    endfunction

    function automatic void compare_field(input string field, input logic [7:0] want,
                                          input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: reply %s expected %h got %h", $time, field, want, got);
            mismatch_total++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        apcp_pkg::out_beat_t due;
        if (!rst_n)
        begin
            held_len = 2'd0;
            port_latch = '{apcp_pkg::LATCH_A_RESET, apcp_pkg::LATCH_B_RESET,
                           apcp_pkg::LATCH_C_RESET};
            owed_replies.delete();
            mismatch_total = 0;
        end
        else
        begin
            if (cmd_valid && cmd_ready)
            begin
                take_cmd_beat(cmd);
            end
            if (reply_valid && reply_ready)
            begin
                if (owed_replies.size() == 0)
                begin
                    $display("%0t: reply beat expected none got %h", $time, reply);
                    mismatch_total++;
                end
                else
                begin
                    due = owed_replies.pop_front();
                    compare_field("tx_char", due.tx_char, reply.tx_char);
                    compare_field("last_char", {7'd0, due.last_char}, {7'd0, reply.last_char});
                    compare_field("latch_a", due.latch_a, reply.latch_a);
                    compare_field("latch_b", due.latch_b, reply.latch_b);
                    compare_field("latch_c", due.latch_c, reply.latch_c);
                end
            end
        end
        replies_owed = owed_replies.size();
    end

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// ASCII port command parser testbench
// Drives directed commands covering every reply kind, bad ports, non-hex
// digits and byte extremes, then a long run of mostly well-formed random
// commands mixed with noise bytes, under random gaps and reply stalls.
// ----------------------------------------------------------------------------
module tb;

    localparam int RANDOM_BYTES = 435;
    localparam int CYCLE_LIMIT = 500000;
    localparam int TAIL_CYCLES = 20;

    logic                clk;
    logic                rst_n;
    logic                cmd_valid;
    logic                cmd_ready;
    apcp_pkg::in_beat_t  cmd;
    logic                reply_valid;
    logic                reply_ready;
    apcp_pkg::out_beat_t reply;
    int                  mismatch_total;
    int                  replies_owed;
    int                  cycle_count = 0;
    int                  steady_left = 0;

    ascii_port_command_parser dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .reply_valid (reply_valid),
        .reply_ready (reply_ready),
        .reply       (reply)
    );

    apcp_reply_checker reply_check
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .cmd            (cmd),
        .reply_valid    (reply_valid),
        .reply_ready    (reply_ready),
        .reply          (reply),
        .mismatch_total (mismatch_total),
        .replies_owed   (replies_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("ascii_port_command_parser verification failed");
        $finish;
    end

    initial
    begin : reply_sink
        int hold;
        int r;
        logic next_ready;
        reply_ready = 1'b0;
        hold = 0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                hold--;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 15)
                begin
                    next_ready = 1'b0;
                    hold = $urandom_range(0, 2);
                end
                else if (r < 18)
                begin
                    next_ready = 1'b0;
                    hold = $urandom_range(20, 60);
                end
                else if (r < 22)
                begin
                    next_ready = 1'b1;
                    hold = $urandom_range(50, 200);
                end
                else
                begin
                    next_ready = 1'b1;
                    hold = $urandom_range(0, 4);
                end
                reply_ready <= next_ready;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (steady_left > 0)
        begin
            steady_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            steady_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 65)
        begin
            return 0;
        end
        if (r < 95)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] random_pins();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            return 8'h00;
        end
        if (r < 20)
        begin
            return 8'hFF;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] hex_char(input int n, input bit lower);
        if (n < 10)
        begin
            return "0" + 8'(n);
        end
        return (lower ? "a" : "A") + 8'(n - 10);
    endfunction

    function automatic logic [7:0] random_digit();
        if ($urandom_range(0, 99) < 8)
        begin
            return 8'($urandom_range(0, 255));
        end
        return hex_char($urandom_range(0, 15), 1'($urandom_range(0, 1)));
    endfunction

    function automatic logic [7:0] random_port_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
        begin
            return hex_char($urandom_range(0, 2), 1'b0);
        end
        if (r < 92)
        begin
            return hex_char($urandom_range(3, 15), 1'($urandom_range(0, 1)));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_beat(input apcp_pkg::in_beat_t beat);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd <= beat;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (!cmd_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic send_char(input logic [7:0] ch);
        send_beat(apcp_pkg::in_beat_t'{ch, random_pins(), random_pins(), random_pins()});
    endtask

    task automatic drain_replies();
        cmd_valid <= 1'b0;
        wait (replies_owed == 0);
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        int sent;
        int r;
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        send_char(apcp_pkg::CHAR_X);
        send_char(apcp_pkg::CHAR_S);
        send_char("0");
        send_char("a");
        send_char("5");
        send_char(apcp_pkg::CHAR_G);
        send_beat(apcp_pkg::in_beat_t'{8'h31, random_pins(), 8'h3C, random_pins()});
        send_char(apcp_pkg::CHAR_S);
        send_char("2");
        send_char("F");
        send_char("0");
        send_char(apcp_pkg::CHAR_G);
        send_beat(apcp_pkg::in_beat_t'{8'h30, 8'hFF, random_pins(), random_pins()});
        send_char(apcp_pkg::CHAR_S);
        send_char("7");
        send_char("z");
        send_char("z");
        send_char(apcp_pkg::CHAR_G);
        send_char("B");
        send_char(apcp_pkg::CHAR_S);
        send_char("q");
        send_char("0");
        send_char("9");
        send_beat(apcp_pkg::in_beat_t'{8'h00, 8'h00, 8'h00, 8'h00});
        send_beat(apcp_pkg::in_beat_t'{8'hFF, 8'hFF, 8'hFF, 8'hFF});
        drain_replies();

        sent = 0;
        while (sent < RANDOM_BYTES)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
            begin
                send_char(apcp_pkg::CHAR_S);
                send_char(random_port_char());
                send_char(random_digit());
                send_char(random_digit());
                sent += 4;
            end
            else if (r < 75)
            begin
                send_char(apcp_pkg::CHAR_G);
                send_char(random_port_char());
                sent += 2;
            end
            else if (r < 80)
            begin
                send_char(apcp_pkg::CHAR_X);
                sent += 1;
            end
            else
            begin
                send_char(8'($urandom_range(0, 255)));
                sent += 1;
            end
            if ($urandom_range(0, 59) == 0)
            begin
                drain_replies();
            end
        end
        cmd_valid <= 1'b0;
        wait (replies_owed == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_total == 0)
        begin
            $display("ascii_port_command_parser verification clean");
        end
        else
        begin
            $display("ascii_port_command_parser verification failed");
        end
        $finish;
    end

endmodule
